[sv/rpn_pkg.sv]
// ----------------------------------------------------------------------------
// RPN calculator package
// Shared types, command codes and status codes.
// ----------------------------------------------------------------------------
package rpn_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int DATA_WIDTH_DEF  = 32;

    typedef enum logic [3:0] {
        MODE_PUSH  = 4'd0,
        MODE_ADD   = 4'd1,
        MODE_SUB   = 4'd2,
        MODE_MUL   = 4'd3,
        MODE_DIV   = 4'd4,
        MODE_NEG   = 4'd5,
        MODE_DUP   = 4'd6,
        MODE_SWAP  = 4'd7,
        MODE_PRINT = 4'd8,
        MODE_CLEAR = 4'd9,
        MODE_PALL  = 4'd10,
        MODE_BAD   = 4'd11
    } t_mode;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_UNDER = 3'd1;
    localparam logic [2:0] ST_DIV0  = 3'd2;
    localparam logic [2:0] ST_BAD   = 3'd3;
    localparam logic [2:0] ST_FULL  = 3'd4;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] push_value;
    } t_cmd;

    typedef struct packed {
        logic [2:0]         status;
        logic               has_value;
        logic signed [31:0] value;
        logic               last;
    } t_res;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_RD_TOP,
        OP_RD_SEC,
        OP_WR_PUSH,
        OP_WR_RES,
        OP_WR_NEG,
        OP_WR_DUP,
        OP_WR_SWAP_HI,
        OP_WR_SWAP_LO,
        OP_DIV_START,
        OP_RD_IDX,
        OP_CLEAR
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [3:0] mode;
    } t_ctl;

    typedef struct packed {
        logic div_done;
        logic div_zero;
    } t_sts;

endpackage

[sv/rpn_div.sv]
// ----------------------------------------------------------------------------
// RPN divider
// Radix-2 restoring signed divide, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module rpn_div #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DATA_WIDTH-1:0] i_a,
    input  logic [DATA_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [DATA_WIDTH-1:0] o_q
);
    localparam int CW = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] r_rem, n_rem;
    logic [DATA_WIDTH-1:0] r_quo, n_quo;
    logic [DATA_WIDTH-1:0] r_den;
    logic                  r_neg;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic [DATA_WIDTH:0]   w_trial;
    logic [DATA_WIDTH:0]   w_shift;

    always_comb begin
        w_shift = {r_rem, r_quo[DATA_WIDTH-1]};
        w_trial = w_shift - {1'b0, r_den};
        n_quo   = {r_quo[DATA_WIDTH-2:0], ~w_trial[DATA_WIDTH]};
        n_rem   = w_trial[DATA_WIDTH] ? w_shift[DATA_WIDTH-1:0] : w_trial[DATA_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DATA_WIDTH);
                r_rem  <= '0;
                r_quo  <= i_a[DATA_WIDTH-1] ? -i_a : i_a;
                r_den  <= i_b[DATA_WIDTH-1] ? -i_b : i_b;
                r_neg  <= i_a[DATA_WIDTH-1] ^ i_b[DATA_WIDTH-1];
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= n_quo;
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_q = r_neg ? -r_quo : r_quo;

endmodule

[sv/rpn_datapath.sv]
// ----------------------------------------------------------------------------
// RPN datapath
// Stack memory, entry count, operand registers, ALU and divider.
// ----------------------------------------------------------------------------
module rpn_datapath #(
    parameter int STACK_DEPTH = 64,
    parameter int DATA_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rpn_pkg::t_ctl         i_ctl,
    input  logic signed [31:0]    i_push_value,
    output rpn_pkg::t_sts         o_sts,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_count,
    output logic [31:0]           o_rd_low
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    logic [DATA_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         r_idx;
    logic [DATA_WIDTH-1:0] r_rd;
    logic [DATA_WIDTH-1:0] r_b;
    logic [DATA_WIDTH-1:0] r_a;
    logic [DATA_WIDTH-1:0] w_res;
    logic [DATA_WIDTH-1:0] w_q;
    logic [DATA_WIDTH-1:0] w_pv;
    logic                  w_div_done;
    logic                  w_we;
    logic [AW-1:0]         w_wa;
    logic [DATA_WIDTH-1:0] w_wd;
    logic [AW-1:0]         w_ra;
    logic [CW-1:0]         w_top, w_sec;

    assign w_top = r_count - CW'(1);
    assign w_sec = r_count - CW'(2);
    assign w_pv  = DATA_WIDTH'({{32{i_push_value[31]}}, i_push_value});

    always_comb begin
        case (t_mode'(i_ctl.mode))
            MODE_ADD: w_res = r_a + r_b;
            MODE_SUB: w_res = r_a - r_b;
            default:  w_res = r_a * r_b;
        endcase
    end

    rpn_div #(.DATA_WIDTH(DATA_WIDTH)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.op == OP_DIV_START),
        .i_a     (r_a),
        .i_b     (r_b),
        .o_done  (w_div_done),
        .o_q     (w_q)
    );

    always_comb begin
        w_we = 1'b1;
        w_wa = w_top[AW-1:0];
        w_wd = r_b;
        w_ra = w_top[AW-1:0];
        case (i_ctl.op)
            OP_WR_PUSH:    begin w_wa = r_count[AW-1:0]; w_wd = w_pv; end
            OP_WR_RES: begin
                w_wa = w_sec[AW-1:0];
                w_wd = (t_mode'(i_ctl.mode) == MODE_DIV) ? w_q : w_res;
            end
            OP_WR_NEG:     w_wd = -r_b;
            OP_WR_DUP:     w_wa = r_count[AW-1:0];
            OP_WR_SWAP_HI: w_wd = r_a;
            OP_WR_SWAP_LO: w_wa = w_sec[AW-1:0];
            OP_RD_SEC:     begin w_we = 1'b0; w_ra = w_sec[AW-1:0]; end
            OP_RD_IDX:     begin w_we = 1'b0; w_ra = r_idx[AW-1:0]; end
            default:       w_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_idx   <= '0;
        end else begin
            case (i_ctl.op)
                OP_WR_PUSH, OP_WR_DUP: r_count <= r_count + CW'(1);
                OP_WR_RES:             r_count <= r_count - CW'(1);
                OP_CLEAR:              r_count <= '0;
                OP_RD_TOP:             r_idx   <= w_top;
                OP_RD_IDX:             r_idx   <= r_idx - CW'(1);
                default:               ;
            endcase
        end
    end

    // operand capture: registered read data of RD_TOP goes to r_b (top), of RD_SEC to r_a (second)
    logic [1:0] r_cap;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= '0;
        end else begin
            r_cap <= {i_ctl.op == OP_RD_SEC, i_ctl.op == OP_RD_TOP};
        end
        if (r_cap[0]) r_b <= r_rd;
        if (r_cap[1]) r_a <= r_rd;
    end

    assign o_sts.div_done = w_div_done;
    assign o_sts.div_zero = (r_b == '0);
    assign o_count        = r_count;
    assign o_rd_low       = 32'({{32{r_rd[DATA_WIDTH-1]}}, r_rd});

endmodule

[sv/rpn_ctrl.sv]
// ----------------------------------------------------------------------------
// RPN controller
// Sequences memory reads, writes, divide and result beats per command.
// ----------------------------------------------------------------------------
module rpn_ctrl #(
    parameter int STACK_DEPTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  rpn_pkg::t_cmd i_cmd,
    output logic          busy,
    output rpn_pkg::t_ctl o_ctl,
    output logic signed [31:0] o_push_value,
    input  rpn_pkg::t_sts i_sts,
    input  logic [$clog2(STACK_DEPTH+1)-1:0] i_count,
    input  logic [31:0]   i_rd_low,
    output logic          o_strobe,
    output rpn_pkg::t_res o_res
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_RDT   = 9'b000000010,
        S_RDS   = 9'b000000100,
        S_WAIT  = 9'b000001000,
        S_EXEC  = 9'b000010000,
        S_DIV   = 9'b000100000,
        S_SWAP  = 9'b001000000,
        S_PALL  = 9'b010000000,
        S_DRAIN = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [CW-1:0] r_left;
    logic          r_pipe;
    t_ctl          w_ctl;
    logic          w_emit;
    t_res          w_res;
    logic          w_acc;
    t_mode         w_m;

    assign w_acc = start && !busy;
    assign busy  = (r_state != S_IDLE);
    assign w_m   = t_mode'(r_cmd.mode);
    assign o_push_value = r_cmd.push_value;

    always_comb begin
        n_state    = r_state;
        w_ctl.op   = OP_NONE;
        w_ctl.mode = r_cmd.mode;
        w_emit     = 1'b0;
        w_res      = '{status: ST_OK, has_value: 1'b0, value: '0, last: 1'b1};
        case (r_state)
            S_IDLE: ;
            S_RDT: begin
                n_state = S_IDLE;
                w_emit  = 1'b1;
                case (w_m)
                    MODE_PUSH: begin
                        if (i_count >= CW'(STACK_DEPTH)) w_res.status = ST_FULL;
                        else w_ctl.op = OP_WR_PUSH;
                    end
                    MODE_ADD, MODE_SUB, MODE_MUL, MODE_DIV, MODE_SWAP: begin
                        if (i_count < CW'(2)) begin
                            w_res.status = ST_UNDER;
                        end else begin
                            w_emit = 1'b0; w_ctl.op = OP_RD_TOP; n_state = S_RDS;
                        end
                    end
                    MODE_NEG, MODE_PRINT: begin
                        if (i_count < CW'(1)) begin
                            w_res.status = ST_UNDER;
                        end else begin
                            w_emit = 1'b0; w_ctl.op = OP_RD_TOP; n_state = S_WAIT;
                        end
                    end
                    MODE_DUP: begin
                        if (i_count < CW'(1)) begin
                            w_res.status = ST_UNDER;
                        end else if (i_count >= CW'(STACK_DEPTH)) begin
                            w_res.status = ST_FULL;
                        end else begin
                            w_emit = 1'b0; w_ctl.op = OP_RD_TOP; n_state = S_WAIT;
                        end
                    end
                    MODE_CLEAR: w_ctl.op = OP_CLEAR;
                    MODE_PALL: begin
                        if (i_count != '0) begin
                            w_emit = 1'b0; w_ctl.op = OP_RD_TOP; n_state = S_PALL;
                        end
                    end
                    default: w_res.status = ST_BAD;
                endcase
            end
            S_RDS: begin
                w_ctl.op = OP_RD_SEC;
                n_state  = S_WAIT;
            end
            S_WAIT: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_IDLE;
                w_emit  = 1'b1;
                case (w_m)
                    MODE_NEG:   w_ctl.op = OP_WR_NEG;
                    MODE_DUP:   w_ctl.op = OP_WR_DUP;
                    MODE_PRINT: begin
                        w_res.has_value = 1'b1;
                        w_res.value     = i_rd_low;
                    end
                    MODE_SWAP: begin
                        w_emit = 1'b0; w_ctl.op = OP_WR_SWAP_HI; n_state = S_SWAP;
                    end
                    MODE_DIV: begin
                        if (i_sts.div_zero) begin
                            w_res.status = ST_DIV0;
                        end else begin
                            w_emit = 1'b0; w_ctl.op = OP_DIV_START; n_state = S_DIV;
                        end
                    end
                    default: w_ctl.op = OP_WR_RES;
                endcase
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    w_ctl.op = OP_WR_RES;
                    w_emit   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            S_SWAP: begin
                w_ctl.op = OP_WR_SWAP_LO;
                w_emit   = 1'b1;
                n_state  = S_IDLE;
            end
            S_PALL: begin
                if (r_left != '0) w_ctl.op = OP_RD_IDX;
                if (r_pipe) begin
                    w_emit          = 1'b1;
                    w_res.has_value = 1'b1;
                    w_res.value     = i_rd_low;
                    w_res.last      = (r_left == '0);
                    if (w_res.last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ctl = w_ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            o_strobe <= 1'b0;
            r_left   <= '0;
            r_pipe   <= 1'b0;
        end else begin
            r_state  <= n_state;
            o_strobe <= w_emit;
            if (r_state == S_RDT) begin
                r_left <= i_count;
            end
            if (w_ctl.op == OP_RD_TOP || w_ctl.op == OP_RD_IDX) begin
                if (r_state == S_PALL) r_left <= r_left - CW'(1);
            end
            // read data is valid in the cycle after a read issue
            r_pipe <= (r_state == S_PALL && w_ctl.op == OP_RD_IDX);
            if (w_acc) begin
                r_state <= S_RDT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) r_cmd <= i_cmd;
        o_res <= w_res;
    end

    always_ff @(posedge i_clk) begin
        if (i_rst_n && o_strobe && o_res.has_value) begin
            assert (o_res.status == ST_OK) else $error("value beat with bad status");
        end
    end

    property p_idle_no_op;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (w_ctl.op == OP_NONE && !w_emit);
    endproperty
    a_idle_no_op: assert property (p_idle_no_op) else $error("op issued while idle");

    property p_emit_idle;
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_res.last) |=> (r_state == S_IDLE || r_state == S_RDT);
    endproperty
    a_emit_idle: assert property (p_emit_idle) else $error("last beat without return");

    property p_div_zero;
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !i_sts.div_zero;
    endproperty
    a_div_zero: assert property (p_div_zero) else $error("divide by zero started");

endmodule

[sv/rpn_stack_calculator.sv]
// ----------------------------------------------------------------------------
// RPN stack calculator
// Reverse Polish integer calculator on a bounded stack, controller plus datapath.
// ----------------------------------------------------------------------------
// Divide produces one quotient bit per cycle; print all gives one beat per cycle
//   for each of its N entries, from the memory port.
// One command at a time; busy high until the last beat is out.
// Synchronous active-low reset empties the stack; memory contents are not cleared.
// Result beats cannot be stalled by the receiver.
module rpn_stack_calculator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF,
    parameter int DATA_WIDTH  = rpn_pkg::DATA_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  rpn_pkg::t_cmd i_cmd,
    output logic          o_strobe,
    output rpn_pkg::t_res o_res
);
    import rpn_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);

    t_ctl               w_ctl;
    t_sts               w_sts;
    logic [CW-1:0]      w_count;
    logic [31:0]        w_rd_low;
    logic signed [31:0] w_pv;

    rpn_ctrl #(.STACK_DEPTH(STACK_DEPTH)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_cmd        (i_cmd),
        .busy         (busy),
        .o_ctl        (w_ctl),
        .o_push_value (w_pv),
        .i_sts        (w_sts),
        .i_count      (w_count),
        .i_rd_low     (w_rd_low),
        .o_strobe     (o_strobe),
        .o_res        (o_res)
    );

    rpn_datapath #(.STACK_DEPTH(STACK_DEPTH), .DATA_WIDTH(DATA_WIDTH)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (w_ctl),
        .i_push_value (w_pv),
        .o_sts        (w_sts),
        .o_count      (w_count),
        .o_rd_low     (w_rd_low)
    );

endmodule
